// ===== rtl/bskp_pkg.sv =====
// Shared types and constants for the bloom soft-knee prefilter.
// Holds the pixel transaction structs, register codes, luma weights and derived widths.
// No dependencies.
package bskp_pkg;

	// Channel and register widths
	localparam int CHANNEL_BITS = 16;
	localparam int THR_W        = 16;
	localparam int KNEE_W       = 9;
	localparam int WEIGHT_W     = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE_RATIO       = 2'd1;

	// Register reset values: threshold 1.0, knee 0.5
	localparam logic [THR_W-1:0]  THR_RESET  = 16'd256;
	localparam logic [KNEE_W-1:0] KNEE_RESET = 9'd128;

	// Rec.709 luma weights in Q0.16, summing to 1.0
	localparam logic [WEIGHT_W-1:0] LUMA_WR = 16'd13933;
	localparam logic [WEIGHT_W-1:0] LUMA_WG = 16'd46871;
	localparam logic [WEIGHT_W-1:0] LUMA_WB = 16'd4732;

	// Derived datapath widths (all values in Q.16 unless noted)
	localparam int LWP_W      = CHANNEL_BITS + WEIGHT_W;       // one weighted channel
	localparam int LUM_W      = CHANNEL_BITS + 8;              // luminance
	localparam int TQ_W       = THR_W + 8;                     // threshold in Q.16
	localparam int K_W        = THR_W + KNEE_W;                // absolute knee
	localparam int AMAG_W     = (LUM_W > K_W) ? LUM_W : K_W;   // magnitude of excess
	localparam int SD_W       = AMAG_W + 1;                    // signed excess
	localparam int SK_W       = SD_W + 1;                      // signed excess plus knee
	localparam int KN_W       = K_W + 1;                       // clamped knee offset
	localparam int SQ_W       = 2 * KN_W;                      // squared offset
	localparam int D1_W       = K_W + 2;                       // four times the knee
	localparam int SCALE_FRAC = 16;
	localparam int N2_W       = AMAG_W + SCALE_FRAC;           // excess shifted to Q.32
	localparam int SCALE_W    = CHANNEL_BITS + SCALE_FRAC;     // clamped scale
	localparam int PROD_W     = CHANNEL_BITS + SCALE_W;        // channel times scale

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] pixel_red;
		logic [CHANNEL_BITS-1:0] pixel_green;
		logic [CHANNEL_BITS-1:0] pixel_blue;
	} pixel_in_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] out_red;
		logic [CHANNEL_BITS-1:0] out_green;
		logic [CHANNEL_BITS-1:0] out_blue;
	} pixel_out_t;

	// Fields carried alongside the soft-knee divider
	typedef struct packed {
		logic signed [SD_W-1:0] diff;
		logic [LUM_W-1:0]       lum;
		pixel_in_t              pix;
		logic                   knee_zero;
	} knee_side_t;

	// Fields carried alongside the scale divider
	typedef struct packed {
		pixel_in_t pix;
		logic      pos;
		logic      ovf;
	} scale_side_t;

endpackage

// ===== rtl/bskp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband bus.
// Standalone; used twice by the prefilter top level. Quotient must fit QUO_W bits.
module bskp_div #(
	parameter int NUM_W  = 52,
	parameter int DEN_W  = 27,
	parameter int QUO_W  = 25,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	// Stage registers: partial remainder, dividend bits merged with quotient bits
	logic [DEN_W-1:0]  rem_s  [QUO_W];
	logic [QUO_W-1:0]  lq_s   [QUO_W];
	logic [DEN_W-1:0]  den_s  [QUO_W];
	logic [SIDE_W-1:0] side_s [QUO_W];
	logic [QUO_W-1:0]  vld_s;

	// Stage inputs and next values
	logic [DEN_W-1:0]  rem_src  [QUO_W];
	logic [QUO_W-1:0]  lq_src   [QUO_W];
	logic [DEN_W-1:0]  den_src  [QUO_W];
	logic [SIDE_W-1:0] side_src [QUO_W];
	logic [QUO_W-1:0]  vld_src;
	logic [DEN_W-1:0]  rem_nx   [QUO_W];
	logic [QUO_W-1:0]  lq_nx    [QUO_W];

	// Select each stage's source: the ports for the first, the previous stage otherwise
	always_comb begin
		rem_src[0]  = DEN_W'(num >> QUO_W);
		lq_src[0]   = num[QUO_W-1:0];
		den_src[0]  = den;
		side_src[0] = side_in;
		vld_src[0]  = in_valid;
		for (int j = 1; j < QUO_W; j++) begin
			rem_src[j]  = rem_s[j-1];
			lq_src[j]   = lq_s[j-1];
			den_src[j]  = den_s[j-1];
			side_src[j] = side_s[j-1];
			vld_src[j]  = vld_s[j-1];
		end
	end

	// One shift-compare-subtract step per stage
	always_comb begin
		logic [DEN_W:0] trial;
		logic [DEN_W:0] sub;
		logic           geq;
		for (int j = 0; j < QUO_W; j++) begin
			trial     = {rem_src[j], lq_src[j][QUO_W-1]};
			sub       = trial - {1'b0, den_src[j]};
			geq       = (trial >= {1'b0, den_src[j]});
			rem_nx[j] = geq ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
			lq_nx[j]  = {lq_src[j][QUO_W-2:0], geq};
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= vld_src;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < QUO_W; j++) begin
				rem_s[j]  <= rem_nx[j];
				lq_s[j]   <= lq_nx[j];
				den_s[j]  <= den_src[j];
				side_s[j] <= side_src[j];
			end
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign quo       = lq_s[QUO_W-1];
	assign side_out  = side_s[QUO_W-1];

endmodule

// ===== rtl/bloom_soft_knee_prefilter_top.sv =====
// Bloom prefilter with a quadratic soft knee: luminance, knee curve, scale, saturate.
// Depends on bskp_pkg and bskp_div.
//
//   channel  signals                          role
//   pixel    in_valid/in_ready/in_data        HDR pixel in, UQ8.8 per channel
//   result   out_valid/out_ready/out_data     scaled pixel out, UQ8.8, saturated
//   config   cfg_we/cfg_index/cfg_wdata       threshold and knee ratio writes
//
// One pixel per clock while the output is not stalled; five front stages, 25 stages
// of the knee divider, two stages, 32 stages of the scale divider, three back stages.
// The bit-serial dividers set the latency; unstalled, every stage takes a new pixel.
// Reset clears all valid bits and loads threshold 1.0 and knee ratio 0.5.
// A result held at the output freezes every stage; a skid register takes one more pixel.
module bloom_soft_knee_prefilter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bskp_pkg::pixel_in_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bskp_pkg::pixel_out_t                out_data,
	input  logic                                cfg_we,
	input  logic [bskp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bskp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import bskp_pkg::*;

	localparam logic [K_W-1:0] K_RESET = K_W'(THR_RESET * KNEE_RESET);
	localparam int             OV_W    = LUM_W + CHANNEL_BITS;
	localparam logic [PROD_W:0] HALF   = (PROD_W + 1)'(1) << (SCALE_FRAC - 1);

	// Round a Q.16 product to the channel grid and clip at the channel maximum
	function automatic logic [CHANNEL_BITS-1:0] round_sat(input logic [PROD_W-1:0] p);
		logic [PROD_W:0] r;
		r = {1'b0, p} + HALF;
		if (r[PROD_W:SCALE_FRAC+CHANNEL_BITS] != '0) begin
			return '1;
		end
		return r[SCALE_FRAC+CHANNEL_BITS-1:SCALE_FRAC];
	endfunction

	logic en;

	// Configuration registers and the derived absolute knee
	logic [THR_W-1:0]  thr_q;
	logic [KNEE_W-1:0] knee_q;
	logic [K_W-1:0]    k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			knee_q <= KNEE_RESET;
			k_q    <= K_RESET;
		end else begin
			k_q <= thr_q * knee_q;
			if (cfg_we) begin
				case (cfg_index)
					REG_BRIGHT_THRESHOLD: thr_q  <= cfg_wdata[THR_W-1:0];
					REG_KNEE_RATIO:       knee_q <= cfg_wdata[KNEE_W-1:0];
					default:              ;
				endcase
			end
		end
	end

	// Input skid register
	logic      skid_valid_q;
	pixel_in_t skid_q;
	logic      src_valid;
	pixel_in_t src_pix;

	assign in_ready  = !skid_valid_q;
	assign src_valid = skid_valid_q | in_valid;
	assign src_pix   = skid_valid_q ? skid_q : in_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (en) begin
			skid_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_valid && in_ready) begin
			skid_q <= in_data;
		end
	end

	// Pipeline registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	pixel_in_t pix_s1, pix_s2, pix_s3, pix_s4, pix_s6, pix_s8;
	logic [LWP_W-1:0]       pr_s1, pg_s1, pb_s1;
	logic [LUM_W-1:0]       lum_s2, lum_s3, lum_s4, lum_s6;
	logic signed [SD_W-1:0] diff_s3, diff_s4, a_s6;
	logic signed [SK_W-1:0] ksum_s3;
	logic [KN_W-1:0]        s_s4;
	logic                   kz_s4;
	logic [SQ_W-1:0]        sq_s5;
	logic [D1_W-1:0]        den1_s5;
	knee_side_t             side1_s5;
	logic [N2_W-1:0]        num2_s7;
	logic [LUM_W-1:0]       den2_s7;
	scale_side_t            side2_s7;
	logic [SCALE_W-1:0]     scale_s8;
	logic [PROD_W-1:0]      prod_r_s9, prod_g_s9, prod_b_s9;
	logic                   out_valid_q;
	pixel_out_t             out_q;

	// Combinational terms between stages
	logic [LWP_W+1:0]       lum_sum;
	logic signed [SD_W-1:0] diff_c;
	logic signed [SK_W-1:0] ksum_c;
	logic [KN_W-1:0]        two_k;
	logic [KN_W-1:0]        s_c;
	logic [K_W-1:0]         contrib_c;
	logic signed [SD_W-1:0] contrib_sx;
	logic [AMAG_W-1:0]      a_mag;
	logic                   pos_c;
	logic                   ovf_c;

	// Divider outputs
	logic        d1_valid;
	logic [K_W-1:0] d1_quo;
	knee_side_t  d1_side;
	logic        d2_valid;
	logic [SCALE_W-1:0] d2_quo;
	scale_side_t d2_side;

	// Stall everything while a result waits at the output
	assign en = !out_valid_q || out_ready;

	// Luminance, excess over threshold, knee offset clamp, knee contribution and scale flags
	always_comb begin
		lum_sum    = (LWP_W + 2)'(pr_s1) + (LWP_W + 2)'(pg_s1) + (LWP_W + 2)'(pb_s1);
		diff_c     = $signed(SD_W'(lum_s2)) - $signed(SD_W'({thr_q, 8'h00}));
		ksum_c     = SK_W'(diff_c) + $signed(SK_W'(k_q));
		two_k      = {k_q, 1'b0};
		if (ksum_s3 < 0) begin
			s_c = '0;
		end else if (ksum_s3 > $signed(SK_W'(two_k))) begin
			s_c = two_k;
		end else begin
			s_c = ksum_s3[KN_W-1:0];
		end
		contrib_c  = d1_side.knee_zero ? '0 : d1_quo;
		contrib_sx = $signed(SD_W'(contrib_c));
		a_mag      = a_s6[AMAG_W-1:0];
		pos_c      = (a_s6 > 0) && (lum_s6 != '0);
		ovf_c      = OV_W'(a_mag) >= {lum_s6, {CHANNEL_BITS{1'b0}}};
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= src_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= d1_valid;
			v_s7        <= v_s6;
			v_s8        <= d2_valid;
			v_s9        <= v_s8;
			out_valid_q <= v_s9;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			// weighted channels
			pix_s1 <= src_pix;
			pr_s1  <= src_pix.pixel_red * LUMA_WR;
			pg_s1  <= src_pix.pixel_green * LUMA_WG;
			pb_s1  <= src_pix.pixel_blue * LUMA_WB;
			// luminance
			pix_s2 <= pix_s1;
			lum_s2 <= lum_sum[LUM_W+7:8];
			// excess and knee offset
			pix_s3  <= pix_s2;
			lum_s3  <= lum_s2;
			diff_s3 <= diff_c;
			ksum_s3 <= ksum_c;
			// clamp the knee offset
			pix_s4  <= pix_s3;
			lum_s4  <= lum_s3;
			diff_s4 <= diff_s3;
			s_s4    <= s_c;
			kz_s4   <= (k_q == '0);
			// square the offset, set up the knee division
			sq_s5            <= s_s4 * s_s4;
			den1_s5          <= {k_q, 2'b00};
			side1_s5.diff      <= diff_s4;
			side1_s5.lum       <= lum_s4;
			side1_s5.pix       <= pix_s4;
			side1_s5.knee_zero <= kz_s4;
			// larger of excess and knee contribution
			pix_s6 <= d1_side.pix;
			lum_s6 <= d1_side.lum;
			a_s6   <= (contrib_sx > d1_side.diff) ? contrib_sx : d1_side.diff;
			// flags and setup of the scale division
			num2_s7      <= (pos_c && !ovf_c) ? {a_mag, {SCALE_FRAC{1'b0}}} : '0;
			den2_s7      <= lum_s6;
			side2_s7.pix <= pix_s6;
			side2_s7.pos <= pos_c;
			side2_s7.ovf <= ovf_c;
			// clamp the scale
			pix_s8   <= d2_side.pix;
			scale_s8 <= !d2_side.pos ? '0 : (d2_side.ovf ? '1 : d2_quo);
			// apply the scale
			prod_r_s9 <= pix_s8.pixel_red * scale_s8;
			prod_g_s9 <= pix_s8.pixel_green * scale_s8;
			prod_b_s9 <= pix_s8.pixel_blue * scale_s8;
			// round and saturate
			out_q.out_red   <= round_sat(prod_r_s9);
			out_q.out_green <= round_sat(prod_g_s9);
			out_q.out_blue  <= round_sat(prod_b_s9);
		end
	end

	// Soft-knee contribution: offset squared over four times the knee
	bskp_div #(
		.NUM_W  (SQ_W),
		.DEN_W  (D1_W),
		.QUO_W  (K_W),
		.SIDE_W ($bits(knee_side_t))
	) u_knee_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.num       (sq_s5),
		.den       (den1_s5),
		.side_in   (side1_s5),
		.out_valid (d1_valid),
		.quo       (d1_quo),
		.side_out  (d1_side)
	);

	// Scale: excess over luminance in Q.16
	bskp_div #(
		.NUM_W  (N2_W),
		.DEN_W  (LUM_W),
		.QUO_W  (SCALE_W),
		.SIDE_W ($bits(scale_side_t))
	) u_scale_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       (num2_s7),
		.den       (den2_s7),
		.side_in   (side2_s7),
		.out_valid (d2_valid),
		.quo       (d2_quo),
		.side_out  (d2_side)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A stalled first stage keeps its transaction
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en |=> v_s1 && $stable(pix_s1))
		else $error("stage 1 lost its transaction during a stall");

	// The skid register drains as soon as the pipeline moves
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && en |=> !skid_valid_q)
		else $error("skid register not drained");

	// The clamped knee offset never exceeds twice the knee
	a_knee_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> s_s4 <= {k_q, 1'b0})
		else $error("knee offset out of range");

	// A zero scale gives black products
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s8 && (scale_s8 == '0) |=>
		(prod_r_s9 == '0) && (prod_g_s9 == '0) && (prod_b_s9 == '0))
		else $error("zero scale produced a nonzero product");

endmodule
